### rtl/core/lcls_pkg.sv
// shared types, constants and pattern tables for the line command led sequencer
package lcls_pkg;

    localparam int LCLS_LINE_BYTES = 64;

    localparam logic [15:0] STEP_TICKS_RESET = 16'd100;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // command keys, last character in the low byte
    localparam int KEY_ON_OFF_W = 80;
    localparam int KEY_ALT_W    = 56;
    localparam int KEY_SHIFT_W  = 72;
    localparam int WIN_W        = KEY_ON_OFF_W;

    localparam logic [KEY_ON_OFF_W-1:0] KEY_ON_OFF = {"LED_", "ON_OFF"};
    localparam logic [KEY_ALT_W-1:0]    KEY_ALT    = "LED_ALT";
    localparam logic [KEY_SHIFT_W-1:0]  KEY_SHIFT  = {"LED_", "SHIFT"};

    localparam logic [7:0] SHIFT_PARK_VALUE = 8'hFE;

    typedef enum logic [1:0] {
        PAT_IDLE   = 2'd0,
        PAT_ON_OFF = 2'd1,
        PAT_ALT    = 2'd2,
        PAT_SHIFT  = 2'd3
    } pat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ECHO_RD,
        ST_ECHO_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept_en;
        logic rd_issue;
        logic scan_step;
        logic finish;
        logic echo_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic line_end;
        logic idx_at_end;
        logic rd_zero;
        logic matched;
        logic idx_last;
        logic out_free;
    } stat_t;

    function automatic logic [5:0] pattern_len(pat_t p);
        logic [5:0] n;
        case (p)
            PAT_ON_OFF: n = 6'd6;
            PAT_ALT:    n = 6'd18;
            PAT_SHIFT:  n = 6'd42;
            default:    n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] pattern_value(pat_t p, logic [5:0] i);
        logic [5:0] m;
        logic [3:0] back;
        logic [7:0] v;
        m    = i;
        back = 4'd0;
        v    = 8'hFF;
        case (p)
            PAT_ON_OFF: v = i[0] ? 8'hFF : 8'h00;
            PAT_ALT:
            begin
                if (i < 6'd6)
                    v = i[0] ? 8'h55 : 8'hAA;
                else if (i < 6'd12)
                    v = i[0] ? 8'h0F : 8'hF0;
                else
                    v = i[0] ? 8'h3C : 8'hC3;
            end
            PAT_SHIFT:
            begin
                // walk out and back, period 14
                if (m >= 6'd28)
                    m = m - 6'd28;
                else if (m >= 6'd14)
                    m = m - 6'd14;
                if (m < 6'd8)
                    v = ~(8'd1 << m[2:0]);
                else
                begin
                    back = 4'd14 - m[3:0];
                    v    = ~(8'd1 << back[2:0]);
                end
            end
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/lcls_ctrl.sv
// sequencing state machine: line scan and echo passes
module lcls_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  lcls_pkg::stat_t stat,
    output lcls_pkg::cmd_t  cmd
);
    import lcls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.line_end)
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (stat.idx_at_end)
                    state_next = stat.matched ? ST_ECHO_RD : ST_IDLE;
                else
                    state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (stat.rd_zero)
                    state_next = stat.matched ? ST_ECHO_RD : ST_IDLE;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_ECHO_RD: state_next = ST_ECHO_OUT;
            ST_ECHO_OUT:
            begin
                if (stat.out_free)
                    state_next = stat.idx_last ? ST_IDLE : ST_ECHO_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.accept_en = 1'b1;
            ST_SCAN_RD:
            begin
                cmd.rd_issue = !stat.idx_at_end;
                cmd.finish   = stat.idx_at_end;
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_step = !stat.rd_zero;
                cmd.finish    = stat.rd_zero;
            end
            ST_ECHO_RD:  cmd.rd_issue  = 1'b1;
            ST_ECHO_OUT: cmd.echo_load = stat.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

### rtl/core/lcls_datapath.sv
// line store, key window, pattern player and output register
module lcls_datapath #(
    parameter int LINE_BYTES = lcls_pkg::LCLS_LINE_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            action,
    input  logic [7:0]      rx_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [7:0]      value,
    output logic            last,
    input  lcls_pkg::cmd_t  cmd,
    output lcls_pkg::stat_t stat
);
    import lcls_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(LINE_BYTES + 1);

    logic [7:0] mem [LINE_BYTES];
    logic [7:0] rd_data_reg;

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [WIN_W-1:0] win_reg, win_next;
    logic [2:0]       hit_reg, hit_next;
    pat_t             pat_reg, pat_next;
    logic [5:0]       step_reg, step_next;
    logic [15:0]      tick_reg, tick_next;
    logic [15:0]      step_ticks_reg;
    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       value_reg, value_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             accept;
    logic             busy_pat;
    logic             is_term;
    logic             line_end;
    logic             store_wr;
    logic             is_tick;
    logic [WIN_W-1:0] win_shift;
    logic [2:0]       hit_now;
    logic [15:0]      tc_dec;
    logic             idx_last;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = cmd.accept_en && out_free;
    assign accept   = in_valid && in_ready;
    assign busy_pat = (pat_reg != PAT_IDLE);
    assign is_term  = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR)
                   || (count_reg >= CW'(LINE_BYTES));
    assign line_end = accept && !action && !busy_pat && is_term;
    assign store_wr = accept && !action && !busy_pat && !is_term;
    assign is_tick  = accept && action;

    // sliding window over the scanned bytes, newest in the low byte
    assign win_shift  = {win_reg[WIN_W-9:0], rd_data_reg};
    assign hit_now[0] = (win_shift == KEY_ON_OFF);
    assign hit_now[1] = (win_shift[KEY_ALT_W-1:0] == KEY_ALT);
    assign hit_now[2] = (win_shift[KEY_SHIFT_W-1:0] == KEY_SHIFT);

    assign tc_dec   = (tick_reg != 16'd0) ? tick_reg - 16'd1 : 16'd0;
    assign idx_last = ((idx_reg + CW'(1)) == count_reg);

    assign stat.line_end   = line_end;
    assign stat.idx_at_end = (idx_reg == count_reg);
    assign stat.rd_zero    = (rd_data_reg == 8'h00);
    assign stat.matched    = |hit_reg;
    assign stat.idx_last   = idx_last;
    assign stat.out_free   = out_free;

    always_ff @(posedge clk)
    begin
        if (store_wr)
            mem[count_reg[AW-1:0]] <= rx_byte;
        if (cmd.rd_issue)
            rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        win_next       = win_reg;
        hit_next       = hit_reg;
        pat_next       = pat_reg;
        step_next      = step_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        // tick while a pattern plays
        if (is_tick && busy_pat)
        begin
            tick_next = tc_dec;
            if (tc_dec == 16'd0)
            begin
                if (step_reg >= pattern_len(pat_reg))
                begin
                    if (pat_reg == PAT_SHIFT)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = 1'b1;
                        value_next     = SHIFT_PARK_VALUE;
                        last_next      = 1'b0;
                    end
                    pat_next  = PAT_IDLE;
                    step_next = 6'd0;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    value_next     = pattern_value(pat_reg, step_reg);
                    last_next      = 1'b0;
                    step_next      = step_reg + 6'd1;
                    tick_next      = (step_ticks_reg == 16'd0) ? 16'd1 : step_ticks_reg;
                end
            end
        end

        if (store_wr)
            count_next = count_reg + CW'(1);

        if (line_end)
        begin
            idx_next = '0;
            win_next = '0;
            hit_next = '0;
        end

        if (cmd.scan_step)
        begin
            win_next = win_shift;
            hit_next = hit_reg | hit_now;
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.finish)
        begin
            if (|hit_reg)
            begin
                if (hit_reg[0])
                    pat_next = PAT_ON_OFF;
                else if (hit_reg[1])
                    pat_next = PAT_ALT;
                else
                    pat_next = PAT_SHIFT;
                step_next = 6'd0;
                tick_next = 16'd0;
                idx_next  = '0;
            end
            else
                count_next = '0;
        end

        if (cmd.echo_load)
        begin
            out_valid_next = 1'b1;
            kind_next      = 1'b0;
            value_next     = rd_data_reg;
            last_next      = idx_last;
            idx_next       = idx_reg + CW'(1);
            if (idx_last)
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            win_reg        <= '0;
            hit_reg        <= '0;
            pat_reg        <= PAT_IDLE;
            step_reg       <= 6'd0;
            tick_reg       <= 16'd0;
            step_ticks_reg <= STEP_TICKS_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            win_reg       <= win_next;
            hit_reg       <= hit_next;
            pat_reg       <= pat_next;
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                step_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

### rtl/core/line_command_led_sequencer_unit.sv
// top level of the line command led sequencer
// input channel (in_valid/in_ready): one beat is a received byte (action 0)
// or one time tick (action 1). output channel (out_valid/out_ready): one
// beat is an echoed line byte (kind 0, last on the final byte) or a new led
// port value (kind 1). cfg_we/cfg_wdata load step_ticks, the ticks each led
// value is held (zero acts as one).
// a tick that shows a value loads it into the output register at the edge
// that takes the tick, and the next beat is taken at once if the output
// register is empty or being drained.
// a line end walks the line store through its single read port, twice on
// a match: the key scan reads the stored bytes in turn, stopping at the
// first zero byte or at the end of the line; on a match the echo then
// reads and sends every stored byte, and in_ready stays low until the
// passes are done.
// a stalled receiver holds the output register and with it the input and the echo:
// in_ready drops until the pending beat is taken.
// reset empties the line, stops any pattern and sets step_ticks to 100;
// the line store itself is not cleared, only entries written since the
// last line end are ever read.
module line_command_led_sequencer_unit #(
    parameter int LINE_BYTES = lcls_pkg::LCLS_LINE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  value,
    output logic        last
);
    import lcls_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing of the scan and echo passes
    lcls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // store, matcher, pattern player and output register
    lcls_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat)
    );

    // no input beat is taken in the middle of an echo
    a_no_accept_mid_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind && !last) |-> !in_ready)
        else $error("input taken while a line echo is in progress");

    // led values never carry the line end mark
    a_led_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> !last)
        else $error("led value marked as last");

    // controller issues at most one datapath step per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_issue, cmd.scan_step, cmd.finish, cmd.echo_load}))
        else $error("conflicting datapath commands");

    // a match is always followed by the echo pass, not by a new input beat
    a_match_echoes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && stat.matched) |=> (!in_ready && !cmd.echo_load && cmd.rd_issue))
        else $error("matched line not echoed");

endmodule

### verif/line_command_led_sequencer_unit_tb.sv
// self-checking testbench for the line command led sequencer: random handshakes, scoreboard
`timescale 1ns / 1ps

module line_command_led_sequencer_unit_tb;

    import lcls_pkg::*;

    localparam int LINE_BYTES = LCLS_LINE_BYTES;

    // input beat actions and output beat kinds
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LED  = 1'b1;

    // long enough for a line end to walk the store twice, plus margin
    localparam int SETTLE_CYCLES = 4 * LINE_BYTES + 40;
    localparam int LONG_HOLD     = 500;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } led_beat_t;

    // dut ports, all inputs driven to known values from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        action    = ACT_BYTE;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  value;
    logic        last;

    // stimulus queue and expected beats
    rx_item_t  rx_items [$];
    led_beat_t awaited_beats [$];
    rx_item_t  next_item;

    // handshake control
    bit          beat_taken      = 1'b0;
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    bit          long_hold_armed = 1'b0;
    int          hold_left       = 0;
    int          cycle_count     = 0;
    int          mismatch_count  = 0;
    logic [15:0] step_now        = STEP_TICKS_RESET;

    // sequencer shadow state
    logic [7:0]  m_line [LINE_BYTES];
    int          m_count = 0;
    pat_t        m_pat   = PAT_IDLE;
    int          m_index = 0;
    int          m_hold  = 0;
    logic [7:0]  m_led   = 8'hFF;
    logic [15:0] m_step  = STEP_TICKS_RESET;

    line_command_led_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // command keys and pattern tables
    // ---------------------------------------------------------------

    function automatic int key_chars(pat_t p);
        case (p)
            PAT_ON_OFF: return KEY_ON_OFF_W / 8;
            PAT_ALT:    return KEY_ALT_W / 8;
            PAT_SHIFT:  return KEY_SHIFT_W / 8;
            default:    return 0;
        endcase
    endfunction

    // keys keep their first character in the top byte
    function automatic logic [7:0] key_char(pat_t p, int i);
        case (p)
            PAT_ON_OFF: return KEY_ON_OFF[(KEY_ON_OFF_W / 8 - 1 - i) * 8 +: 8];
            PAT_ALT:    return KEY_ALT[(KEY_ALT_W / 8 - 1 - i) * 8 +: 8];
            PAT_SHIFT:  return KEY_SHIFT[(KEY_SHIFT_W / 8 - 1 - i) * 8 +: 8];
            default:    return 8'd0;
        endcase
    endfunction

    function automatic int pattern_steps(pat_t p);
        case (p)
            PAT_ON_OFF: return 6;
            PAT_ALT:    return 18;
            PAT_SHIFT:  return 42;
            default:    return 0;
        endcase
    endfunction

    function automatic logic [7:0] led_step_value(pat_t p, int i);
        logic [7:0] v;
        v = 8'hFF;
        case (p)
            PAT_ON_OFF: v = (i % 2) ? 8'hFF : 8'h00;
            PAT_ALT:
            begin
                if (i < 6)
                    v = (i % 2) ? 8'h55 : 8'hAA;
                else if (i < 12)
                    v = (i % 2) ? 8'h0F : 8'hF0;
                else
                    v = (i % 2) ? 8'h3C : 8'hC3;
            end
            PAT_SHIFT:
            begin
                // the dark led walks up and back down
                case (i % 14)
                    0:       v = 8'hFE;
                    1:       v = 8'hFD;
                    2:       v = 8'hFB;
                    3:       v = 8'hF7;
                    4:       v = 8'hEF;
                    5:       v = 8'hDF;
                    6:       v = 8'hBF;
                    7:       v = 8'h7F;
                    8:       v = 8'hBF;
                    9:       v = 8'hDF;
                    10:      v = 8'hEF;
                    11:      v = 8'hF7;
                    12:      v = 8'hFB;
                    default: v = 8'hFD;
                endcase
            end
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // sequencer prediction
    // ---------------------------------------------------------------

    function automatic void await_beat(logic k, logic [7:0] v, logic l);
        awaited_beats.push_back('{kind: k, value: v, last: l});
    endfunction

    // key search over the first len stored bytes
    function automatic bit line_holds(int len, pat_t p);
        int klen;
        bit hit;
        klen = key_chars(p);
        for (int s = 0; s + klen <= len; s++)
        begin
            hit = 1'b1;
            for (int k = 0; k < klen; k++)
                if (m_line[s + k] != key_char(p, k))
                    hit = 1'b0;
            if (hit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_line();
        int   len;
        pat_t p;
        len = 0;
        p   = PAT_IDLE;
        // the search stops at the first zero byte, the echo does not
        while (len < m_count && m_line[len] != 8'd0)
            len++;
        if (line_holds(len, PAT_ON_OFF))
            p = PAT_ON_OFF;
        else if (line_holds(len, PAT_ALT))
            p = PAT_ALT;
        else if (line_holds(len, PAT_SHIFT))
            p = PAT_SHIFT;
        if (p != PAT_IDLE)
        begin
            for (int i = 0; i < m_count; i++)
                await_beat(KIND_ECHO, m_line[i], i == m_count - 1);
            // first led value waits for the next tick
            m_pat   = p;
            m_index = 0;
            m_hold  = 0;
        end
        m_count = 0;
    endfunction

    function automatic void sequencer_step(logic act, logic [7:0] b);
        if (act == ACT_TICK)
        begin
            if (m_pat == PAT_IDLE)
                return;
            if (m_hold > 0)
                m_hold--;
            if (m_hold != 0)
                return;
            if (m_index >= pattern_steps(m_pat))
            begin
                // shift parks on its first value when it ends
                if (m_pat == PAT_SHIFT)
                begin
                    m_led = SHIFT_PARK_VALUE;
                    await_beat(KIND_LED, m_led, 1'b0);
                end
                m_pat   = PAT_IDLE;
                m_index = 0;
                return;
            end
            m_led = led_step_value(m_pat, m_index);
            m_index++;
            m_hold = (m_step == 16'd0) ? 1 : int'(m_step);
            await_beat(KIND_LED, m_led, 1'b0);
            return;
        end
        // bytes are dropped while a pattern plays
        if (m_pat != PAT_IDLE)
            return;
        if (b == CHAR_LF || b == CHAR_CR || m_count >= LINE_BYTES)
        begin
            close_line();
            return;
        end
        m_line[m_count] = b;
        m_count++;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic void queue_item(logic act, logic [7:0] b);
        rx_items.push_back('{act: act, data: b});
    endfunction

    function automatic void queue_ticks(int n);
        for (int i = 0; i < n; i++)
            queue_item(ACT_TICK, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(ACT_BYTE, s[i]);
    endfunction

    function automatic void queue_key(pat_t p);
        for (int i = 0; i < key_chars(p); i++)
            queue_item(ACT_BYTE, key_char(p, i));
    endfunction

    // line content that neither ends a line nor cuts the search
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    function automatic logic [7:0] line_end_char();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    function automatic void append_key(ref logic [7:0] q [$], input pat_t p);
        for (int i = 0; i < key_chars(p); i++)
            q.push_back(key_char(p, i));
    endfunction

    // one line and, on a match, exactly the ticks that play the pattern out;
    // returns the number of line beats it queued
    function automatic int queue_one_sequence();
        logic [7:0] line_q [$];
        logic [7:0] orig;
        pat_t       first_key;
        pat_t       second_key;
        pat_t       won;
        int         sel;
        int         pos;
        int         pre_len;
        int         ticks;
        int         hold;
        bit         fill;
        bit         broken;
        bit         zero_front;
        bit         zero_back;
        bit         two_keys;
        sel = $urandom_range(0, 99);
        // ticks while idle are ignored
        if (sel < 8)
        begin
            queue_ticks($urandom_range(1, 3));
            return 0;
        end
        // empty line
        if (sel < 14)
        begin
            queue_item(ACT_BYTE, line_end_char());
            return 1;
        end
        first_key  = pat_t'(2'($urandom_range(1, 3)));
        second_key = pat_t'(2'($urandom_range(1, 3)));
        broken     = (sel < 30);
        zero_front = (sel >= 30 && sel < 36);
        zero_back  = (sel >= 36 && sel < 44);
        two_keys   = !broken && ($urandom_range(0, 5) == 0);
        fill       = ($urandom_range(0, 9) == 0);
        append_key(line_q, first_key);
        if (broken)
        begin
            // near miss: one key character replaced
            pos  = $urandom_range(0, key_chars(first_key) - 1);
            orig = line_q[pos];
            do
                line_q[pos] = filler_byte();
            while (line_q[pos] == orig);
        end
        if (two_keys)
            append_key(line_q, second_key);
        if (zero_back)
            line_q.push_back(8'd0);
        repeat ($urandom_range(0, 4))
            line_q.push_back(filler_byte());
        if (zero_front)
            line_q.push_front(8'd0);
        pre_len = fill ? LINE_BYTES - line_q.size() : $urandom_range(0, 6);
        repeat (pre_len)
            line_q.push_front(filler_byte());
        foreach (line_q[i])
            queue_item(ACT_BYTE, line_q[i]);
        // a full store is closed by any byte
        queue_item(ACT_BYTE, fill ? 8'($urandom_range(0, 255)) : line_end_char());
        won = first_key;
        if (two_keys && second_key < first_key)
            won = second_key;
        if (broken || zero_front)
            won = PAT_IDLE;
        if (won != PAT_IDLE)
        begin
            hold  = (step_now == 16'd0) ? 1 : int'(step_now);
            ticks = pattern_steps(won) * hold + 1;
            for (int t = 0; t < ticks; t++)
            begin
                queue_item(ACT_TICK, 8'($urandom_range(0, 255)));
                // noise while playing, never after the closing tick
                if (t < ticks - 1 && $urandom_range(0, 15) == 0)
                    queue_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
        end
        return line_q.size() + 1;
    endfunction

    // budget counts every queued beat, ticks included
    task automatic queue_random_lines(int budget);
        int start;
        start = rx_items.size();
        while (rx_items.size() - start < budget)
            void'(queue_one_sequence());
    endtask

    // register writes only happen with the block quiet
    task automatic write_step(logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        step_now = v;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (rx_items.size() != 0 || in_valid || awaited_beats.size() != 0);
        // a line end without a match still keeps the block busy a while
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // driver: one input beat at a time, changed at the falling edge
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (rx_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_item = rx_items.pop_front();
                in_valid <= 1'b1;
                action   <= next_item.act;
                rx_byte  <= next_item.data;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold once armed
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (long_hold_armed && out_valid)
        begin
            long_hold_armed = 1'b0;
            hold_left       = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // monitor: compares output beats, feeds accepted input beats to the shadow
    // ---------------------------------------------------------------

    function automatic void check_beat(logic k, logic [7:0] v, logic l);
        led_beat_t want;
        if (awaited_beats.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("unexpected beat: kind %0d value %02h last %0d", k, v, l);
            mismatch_count++;
            return;
        end
        want = awaited_beats.pop_front();
        if (want.kind !== k || want.value !== v || want.last !== l)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("beat mismatch: expected kind %0d value %02h last %0d,",
                         want.kind, want.value, want.last,
                         " got kind %0d value %02h last %0d", k, v, l);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            // outputs first: a beat taken now cannot cause a result on this edge
            if (out_valid && out_ready)
                check_beat(kind, value, last);
            if (cfg_we)
                m_step = cfg_wdata;
            beat_taken = in_valid && in_ready;
            if (beat_taken)
                sequencer_step(action, rx_byte);
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial
    begin
        send_idle_pct = 38;
        recv_idle_pct = 61;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset hold, no pattern started
        queue_ticks(1);                         // tick while idle
        queue_item(ACT_BYTE, CHAR_CR);          // empty line
        queue_item(ACT_BYTE, CHAR_LF);
        queue_text("LED");                      // no command
        queue_item(ACT_BYTE, CHAR_CR);
        queue_item(ACT_BYTE, 8'h00);            // zero hides the key
        queue_text("LED_ALT");
        queue_item(ACT_BYTE, CHAR_LF);
        wait_drained();

        // shortest hold; receiver holds off long enough to back up the input
        write_step(16'd1);
        long_hold_armed = 1'b1;
        queue_key(PAT_ON_OFF);                  // match, echo carries zero and extremes
        queue_item(ACT_BYTE, 8'hFF);
        queue_item(ACT_BYTE, 8'h00);
        queue_item(ACT_BYTE, 8'h80);
        queue_item(ACT_BYTE, CHAR_CR);
        queue_ticks(1);                         // first value on the next tick
        queue_text("A");                        // dropped while playing, line end too
        queue_item(ACT_BYTE, CHAR_CR);
        queue_ticks(6);                         // rest of on/off, then idle
        queue_item(ACT_BYTE, CHAR_CR);
        queue_random_lines(25);
        wait_drained();

        // zero hold acts as one
        send_idle_pct = 61;
        recv_idle_pct = 38;
        write_step(16'd0);
        queue_random_lines(25);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step(16'd2);
        queue_random_lines(20);
        wait_drained();

        // longest hold: only the first shift value shows, the rest is dropped
        write_step(16'hFFFF);
        queue_key(PAT_SHIFT);
        queue_item(ACT_BYTE, CHAR_LF);
        queue_ticks(2);
        queue_text("LED_ALT");
        queue_item(ACT_BYTE, CHAR_CR);
        queue_ticks(1);
        wait_drained();

        if (mismatch_count == 0 && awaited_beats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
